// File: rtl/pls_pkg.sv
// shared types and constants for the positional list store
package pls_pkg;

    // default number of entries held
    localparam int CAPACITY_DEF = 64;

    // operation codes of a transaction
    typedef enum logic [2:0] {
        KIND_INS_FRONT = 3'd0,
        KIND_INS_BACK  = 3'd1,
        KIND_INS_AT    = 3'd2,
        KIND_DEL_FRONT = 3'd3,
        KIND_DEL_BACK  = 3'd4,
        KIND_DEL_AT    = 3'd5
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_INS_RD,
        S_INS_WR,
        S_TAKE_RD,
        S_TAKE_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_FINISH
    } state_t;

    // memory read address select
    typedef enum logic [1:0] {
        RD_HERE,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    setup;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_shift;
        logic    wr_value;
        logic    capture;
        logic    finish;
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic ins_go;
        logic del_go;
        logic more;
    } stat_t;

endpackage

// File: rtl/pls_ctrl.sv
// controller state machine for the positional list store
module pls_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  pls_pkg::stat_t stat,
    output pls_pkg::ctl_t  ctl,
    output logic           busy
);

    pls_pkg::state_t state_reg;
    pls_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pls_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pls_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = pls_pkg::S_SETUP;
                end
            end
            pls_pkg::S_SETUP:
            begin
                if (stat.ins_go)
                begin
                    state_next = pls_pkg::S_INS_RD;
                end
                else if (stat.del_go)
                begin
                    state_next = pls_pkg::S_TAKE_RD;
                end
                else
                begin
                    state_next = pls_pkg::S_FINISH;
                end
            end
            pls_pkg::S_INS_RD:
            begin
                state_next = stat.more ? pls_pkg::S_INS_WR : pls_pkg::S_FINISH;
            end
            pls_pkg::S_INS_WR:
            begin
                state_next = pls_pkg::S_INS_RD;
            end
            pls_pkg::S_TAKE_RD:
            begin
                state_next = pls_pkg::S_TAKE_WR;
            end
            pls_pkg::S_TAKE_WR:
            begin
                state_next = pls_pkg::S_DEL_RD;
            end
            pls_pkg::S_DEL_RD:
            begin
                state_next = stat.more ? pls_pkg::S_DEL_WR : pls_pkg::S_FINISH;
            end
            pls_pkg::S_DEL_WR:
            begin
                state_next = pls_pkg::S_DEL_RD;
            end
            pls_pkg::S_FINISH:
            begin
                state_next = pls_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pls_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        ctl        = '0;
        ctl.rd_sel = pls_pkg::RD_HERE;
        busy       = 1'b1;
        case (state_reg)
            pls_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            pls_pkg::S_SETUP:
            begin
                ctl.setup = 1'b1;
            end
            pls_pkg::S_INS_RD:
            begin
                if (stat.more)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = pls_pkg::RD_PREV;
                end
                else
                begin
                    ctl.wr_value = 1'b1;
                end
            end
            pls_pkg::S_INS_WR:
            begin
                ctl.wr_shift = 1'b1;
            end
            pls_pkg::S_TAKE_RD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = pls_pkg::RD_HERE;
            end
            pls_pkg::S_TAKE_WR:
            begin
                ctl.capture = 1'b1;
            end
            pls_pkg::S_DEL_RD:
            begin
                if (stat.more)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = pls_pkg::RD_NEXT;
                end
            end
            pls_pkg::S_DEL_WR:
            begin
                ctl.wr_shift = 1'b1;
            end
            pls_pkg::S_FINISH:
            begin
                ctl.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/pls_datapath.sv
// entry memory, count, checks and result registers of the positional list store
module pls_datapath
#(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  pls_pkg::ctl_t       ctl,
    output pls_pkg::stat_t      stat,
    input  logic [2:0]          kind,
    input  logic signed [31:0]  value,
    input  logic [6:0]          position,
    output logic                done,
    output logic signed [31:0]  removed_value,
    output logic [1:0]          status,
    output logic [6:0]          entry_count
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > 7) ? CW : 7;
    localparam logic [CMP_W-1:0] CAP_W = CMP_W'(CAPACITY);

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rd_data_reg;
    logic signed [31:0] rd_data;

    pls_pkg::kind_t     kind_reg;
    logic signed [31:0] value_reg;
    logic [6:0]         pos_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      idx_next;
    logic signed [31:0] taken_reg;

    logic               done_reg;
    logic signed [31:0] removed_reg;
    pls_pkg::status_t   status_reg;
    logic [6:0]         entry_count_reg;

    logic [CMP_W-1:0]   count_w;
    logic [CMP_W-1:0]   pos_w;
    logic [CMP_W-1:0]   where_w;
    logic [CMP_W-1:0]   count_out_w;
    logic [AW-1:0]      where_a;
    logic [AW-1:0]      rd_addr;
    logic               is_ins;
    logic               is_del;
    pls_pkg::status_t   st;

    assign count_w = CMP_W'(count_reg);
    assign pos_w   = CMP_W'(pos_reg);

    // decode of the latched transaction
    always_comb
    begin
        is_ins = kind_reg inside {pls_pkg::KIND_INS_FRONT, pls_pkg::KIND_INS_BACK,
                                  pls_pkg::KIND_INS_AT};
        is_del = kind_reg inside {pls_pkg::KIND_DEL_FRONT, pls_pkg::KIND_DEL_BACK,
                                  pls_pkg::KIND_DEL_AT};
        case (kind_reg)
            pls_pkg::KIND_INS_FRONT: where_w = '0;
            pls_pkg::KIND_INS_BACK:  where_w = count_w;
            pls_pkg::KIND_INS_AT:    where_w = pos_w;
            pls_pkg::KIND_DEL_FRONT: where_w = '0;
            pls_pkg::KIND_DEL_BACK:  where_w = count_w - CMP_W'(1);
            pls_pkg::KIND_DEL_AT:    where_w = pos_w;
            default:                 where_w = '0;
        endcase
    end

    assign where_a = where_w[AW-1:0];

    // full, empty and range checks, full and empty take priority
    always_comb
    begin
        st = pls_pkg::STAT_OK;
        if (is_ins)
        begin
            if (count_w == CAP_W)
            begin
                st = pls_pkg::STAT_FULL;
            end
            else if (where_w > count_w)
            begin
                st = pls_pkg::STAT_RANGE;
            end
        end
        else if (is_del)
        begin
            if (count_w == '0)
            begin
                st = pls_pkg::STAT_EMPTY;
            end
            else if (where_w >= count_w)
            begin
                st = pls_pkg::STAT_RANGE;
            end
        end
    end

    // status toward the controller
    always_comb
    begin
        stat.ins_go = is_ins && (st == pls_pkg::STAT_OK);
        stat.del_go = is_del && (st == pls_pkg::STAT_OK);
        if (is_ins)
        begin
            stat.more = idx_reg > where_a;
        end
        else
        begin
            stat.more = (CMP_W'(idx_reg) + CMP_W'(1)) < count_w;
        end
    end

    // read address select
    always_comb
    begin
        case (ctl.rd_sel)
            pls_pkg::RD_HERE: rd_addr = idx_reg;
            pls_pkg::RD_PREV: rd_addr = idx_reg - AW'(1);
            pls_pkg::RD_NEXT: rd_addr = idx_reg + AW'(1);
            default:          rd_addr = idx_reg;
        endcase
    end

    // entry memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_shift)
        begin
            mem[idx_reg] <= rd_data_reg;
        end
        else if (ctl.wr_value)
        begin
            mem[idx_reg] <= value_reg;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // walk index, down for inserts and up for deletes
    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.setup)
        begin
            idx_next = is_ins ? count_w[AW-1:0] : where_a;
        end
        else if (ctl.wr_shift)
        begin
            idx_next = is_ins ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
        end
    end

    // transaction payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            kind_reg  <= pls_pkg::kind_t'(kind);
            value_reg <= value;
            pos_reg   <= position;
        end
        if (ctl.capture)
        begin
            taken_reg <= rd_data;
        end
        idx_reg <= idx_next;
    end

    assign rd_data = rd_data_reg;

    // count after the operation
    always_comb
    begin
        count_next = count_reg;
        if (ctl.finish)
        begin
            if (stat.ins_go)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (stat.del_go)
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    assign count_out_w = CMP_W'(count_next);

    // count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= ctl.finish;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            removed_reg     <= stat.del_go ? taken_reg : 32'sd0;
            status_reg      <= st;
            entry_count_reg <= count_out_w[6:0];
        end
    end

    assign done          = done_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign entry_count   = entry_count_reg;

endmodule

// File: rtl/positional_list_store.sv
// top level of the positional list store
//
// Ordered store of up to CAPACITY signed 32-bit words with insert and delete at the front,
// the back or a 0-based position. A transaction is taken when start is high and busy is
// low; the result is shown for exactly one cycle with done high, and the receiver cannot
// stall it. Entries live in a single memory with one write and one registered read port,
// so every entry that moves is read and then written in its new place. A rejected or
// unused operation goes from setup to finish; an insert shifts entries back from the end,
// then writes the new word; a delete captures its word, then shifts later entries forward.
// busy drops in the cycle that done is high, so the next transaction can be taken right then.
// No clearing pass follows reset: the store starts empty with its count at zero.
module positional_list_store
#(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         kind,
    input  logic signed [31:0] value,
    input  logic [6:0]         position,
    output logic               done,
    output logic signed [31:0] removed_value,
    output logic [1:0]         status,
    output logic [6:0]         entry_count
);

    pls_pkg::ctl_t  ctl;
    pls_pkg::stat_t stat;

    // sequencer
    pls_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // storage and checks
    pls_datapath
    #(
        .CAPACITY (CAPACITY)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .kind          (kind),
        .value         (value),
        .position      (position),
        .done          (done),
        .removed_value (removed_value),
        .status        (status),
        .entry_count   (entry_count)
    );

`ifndef SYNTHESIS
    // a result only shows while the controller is free
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // results never come in adjacent cycles
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // failed operations return no word
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != pls_pkg::STAT_OK)) |-> (removed_value == 32'sd0))
        else $error("failed operation returned a word");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the positional list store
module tb_top;

    localparam int CAPACITY = pls_pkg::CAPACITY_DEF;
    // codes that name no operation: the store must leave itself alone
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;
    localparam int RANDOM_ITEMS = 1900;
    // no idling once this few transactions are left
    localparam int TAIL_ITEMS = 200;
    // slowest run is about 1924 transactions that each move a full store, plus an idle gap each
    localparam int LIMIT_CYCLES = 1200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] word;
        logic [6:0]         pos;
    } list_op_t;

    typedef struct {
        logic signed [31:0] removed;
        pls_pkg::status_t   status;
        logic [6:0]         count;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         kind = pls_pkg::KIND_INS_FRONT;
    logic signed [31:0] value = '0;
    logic [6:0]         position = '0;
    logic               busy;
    logic               done;
    logic signed [31:0] removed_value;
    logic [1:0]         status;
    logic [6:0]         entry_count;

    // stimulus waiting to be driven and results still owed by the store
    list_op_t     op_queue[$];
    list_result_t due_results[$];

    // predicted contents of the store
    logic signed [31:0] held_words[CAPACITY];
    int                 held_count = 0;

    // entry count as the stimulus generator expects it, used to aim positions
    int gen_count = 0;

    int       error_count = 0;
    int       taken_count = 0;
    int       result_count = 0;
    int       cycle_count = 0;
    int       gap_left = 0;
    int       calm_left = 0;
    bit       took;
    list_op_t cur_op;

    positional_list_store u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .value         (value),
        .position      (position),
        .done          (done),
        .removed_value (removed_value),
        .status        (status),
        .entry_count   (entry_count)
    );

    always #6 clk = ~clk;

    // put a word at an index, moving later entries back
    function automatic pls_pkg::status_t insert_word(logic signed [31:0] word, int where);
        if (held_count >= CAPACITY)
            return pls_pkg::STAT_FULL;
        if (where > held_count)
            return pls_pkg::STAT_RANGE;
        for (int i = held_count; i > where; i--)
            held_words[i] = held_words[i - 1];
        held_words[where] = word;
        held_count++;
        return pls_pkg::STAT_OK;
    endfunction

    // take the word at an index, closing the gap behind it
    function automatic pls_pkg::status_t remove_word(int where,
                                                     output logic signed [31:0] word);
        word = '0;
        if (held_count == 0)
            return pls_pkg::STAT_EMPTY;
        if (where >= held_count)
            return pls_pkg::STAT_RANGE;
        word = held_words[where];
        for (int i = where; i + 1 < held_count; i++)
            held_words[i] = held_words[i + 1];
        held_count--;
        return pls_pkg::STAT_OK;
    endfunction

    // apply one transaction to the predicted store and return what the block must report
    function automatic list_result_t apply_list_op(list_op_t op);
        list_result_t       res;
        logic signed [31:0] taken;
        taken = '0;
        res.status = pls_pkg::STAT_OK;
        case (op.op)
            pls_pkg::KIND_INS_FRONT: res.status = insert_word(op.word, 0);
            pls_pkg::KIND_INS_BACK:  res.status = insert_word(op.word, held_count);
            pls_pkg::KIND_INS_AT:    res.status = insert_word(op.word, int'(op.pos));
            pls_pkg::KIND_DEL_FRONT: res.status = remove_word(0, taken);
            pls_pkg::KIND_DEL_BACK:
                res.status = remove_word(held_count == 0 ? 0 : held_count - 1, taken);
            pls_pkg::KIND_DEL_AT:    res.status = remove_word(int'(op.pos), taken);
            default:                 ;
        endcase
        res.removed = taken;
        res.count = held_count[6:0];
        return res;
    endfunction

    task automatic note_error(string msg);
        $display("mismatch at result %0d: %s", result_count, msg);
        error_count++;
    endtask

    // queue a transaction and follow the entry count it should leave
    task automatic queue_op(logic [2:0] op, logic signed [31:0] word, logic [6:0] pos);
        list_op_t item;
        item.op = op;
        item.word = word;
        item.pos = pos;
        op_queue.push_back(item);
        case (op)
            pls_pkg::KIND_INS_FRONT, pls_pkg::KIND_INS_BACK, pls_pkg::KIND_INS_AT:
                if (gen_count < CAPACITY && (op != pls_pkg::KIND_INS_AT || pos <= gen_count))
                    gen_count++;
            pls_pkg::KIND_DEL_FRONT, pls_pkg::KIND_DEL_BACK, pls_pkg::KIND_DEL_AT:
                if (gen_count > 0 && (op != pls_pkg::KIND_DEL_AT || pos < gen_count))
                    gen_count--;
            default: ;
        endcase
    endtask

    // stimulus, reset and end of run
    initial
    begin
        int                 made;
        int                 phase;
        int                 phase_len;
        int                 ins_pct;
        int                 pick;
        logic [2:0]         op;
        logic signed [31:0] word;
        logic [6:0]         pos;

        // directed: empty store, single entries, ends of the list, ranges, spare codes
        queue_op(pls_pkg::KIND_DEL_FRONT, 32'sd5, 7'd0);
        queue_op(pls_pkg::KIND_DEL_BACK, 32'sd5, 7'd0);
        queue_op(pls_pkg::KIND_DEL_AT, 32'sd5, 7'd0);
        queue_op(pls_pkg::KIND_INS_AT, 32'sd9, 7'd1);
        queue_op(pls_pkg::KIND_INS_AT, 32'sh7FFFFFFF, 7'd0);
        queue_op(pls_pkg::KIND_DEL_AT, 32'sd0, 7'd0);
        queue_op(pls_pkg::KIND_INS_BACK, 32'sh80000000, 7'd0);
        queue_op(pls_pkg::KIND_DEL_BACK, 32'sd0, 7'd0);
        queue_op(pls_pkg::KIND_INS_FRONT, -32'sd1, 7'd0);
        queue_op(pls_pkg::KIND_DEL_FRONT, 32'sd0, 7'd0);
        queue_op(pls_pkg::KIND_INS_FRONT, 32'sd1, 7'd0);
        queue_op(pls_pkg::KIND_INS_BACK, 32'sh80000000, 7'd0);
        queue_op(pls_pkg::KIND_INS_AT, 32'sh7FFFFFFF, 7'd2);
        queue_op(pls_pkg::KIND_INS_AT, 32'sh55555555, 7'd1);
        queue_op(pls_pkg::KIND_INS_AT, 32'sd3, 7'd127);
        queue_op(pls_pkg::KIND_DEL_AT, 32'sd0, 7'd4);
        queue_op(pls_pkg::KIND_DEL_AT, 32'sd0, 7'd127);
        queue_op(KIND_SPARE6, 32'shAAAAAAAA, 7'd127);
        queue_op(KIND_SPARE7, 32'sh55555555, 7'd0);
        queue_op(pls_pkg::KIND_DEL_AT, 32'sd0, 7'd1);
        queue_op(pls_pkg::KIND_DEL_BACK, 32'sd0, 7'd0);
        queue_op(pls_pkg::KIND_INS_AT, 32'sd7, 7'd64);
        queue_op(pls_pkg::KIND_DEL_FRONT, 32'sd0, 7'd0);
        queue_op(pls_pkg::KIND_DEL_FRONT, 32'sd0, 7'd0);

        // random: phases that fill, drain or churn the store
        made = 0;
        phase = 0;
        while (made < RANDOM_ITEMS)
        begin
            ins_pct = (phase % 3 == 0) ? 85 : (phase % 3 == 1) ? 15 : 50;
            phase_len = $urandom_range(60, 160);
            for (int n = 0; n < phase_len && made < RANDOM_ITEMS; n++)
            begin
                pick = $urandom_range(0, 2);
                if ($urandom_range(0, 49) == 0)
                    op = pick[0] ? KIND_SPARE7 : KIND_SPARE6;
                else if ($urandom_range(0, 99) < ins_pct)
                    op = (pick == 0) ? pls_pkg::KIND_INS_FRONT :
                         (pick == 1) ? pls_pkg::KIND_INS_BACK : pls_pkg::KIND_INS_AT;
                else
                    op = (pick == 0) ? pls_pkg::KIND_DEL_FRONT :
                         (pick == 1) ? pls_pkg::KIND_DEL_BACK : pls_pkg::KIND_DEL_AT;

                case ($urandom_range(0, 9))
                    0:       word = 32'sh7FFFFFFF;
                    1:       word = 32'sh80000000;
                    2:       word = '0;
                    3:       word = -32'sd1;
                    default: word = $urandom;
                endcase

                // mostly valid positions with the ends favored, some anywhere in the field
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    pos = 7'($urandom_range(0, 127));
                else if (op == pls_pkg::KIND_INS_AT)
                    pos = 7'((pick == 1) ? gen_count : (pick == 2) ? 0 :
                             $urandom_range(0, gen_count));
                else if (gen_count == 0)
                    pos = 7'd0;
                else
                    pos = 7'((pick == 1) ? gen_count - 1 : $urandom_range(0, gen_count - 1));

                queue_op(op, word, pos);
                made++;
            end
            phase++;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || start)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASS positional_list_store");
        else
            $display("FAIL positional_list_store");
        $finish;
    end

    // driver: present transactions, predict each one as it is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took = start && !busy;
            if (took)
            begin
                due_results.push_back(apply_list_op(cur_op));
                taken_count++;
            end
            if (!start || took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (op_queue.size() == 0)
                begin
                    start <= 1'b0;
                end
                else if (op_queue.size() > TAIL_ITEMS && calm_left == 0
                         && $urandom_range(0, 5) == 0)
                begin
                    gap_left = $urandom_range(1, 15) - 1;
                    start <= 1'b0;
                end
                else
                begin
                    // now and then a stretch of back-to-back transactions
                    if (calm_left > 0)
                        calm_left--;
                    else if ($urandom_range(0, 19) == 0)
                        calm_left = $urandom_range(10, 60);
                    cur_op = op_queue.pop_front();
                    start <= 1'b1;
                    kind <= cur_op.op;
                    value <= cur_op.word;
                    position <= cur_op.pos;
                end
            end
        end
    end

    // monitor: check each strobed result against the oldest prediction
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
            begin
                note_error($sformatf("result with no transaction outstanding (count %0d)",
                                     entry_count));
            end
            else
            begin
                want = due_results.pop_front();
                if (removed_value !== want.removed)
                    note_error($sformatf("removed_value %0d, expected %0d",
                                         removed_value, want.removed));
                if (status !== want.status)
                    note_error($sformatf("status %0d, expected %0d", status, want.status));
                if (entry_count !== want.count)
                    note_error($sformatf("entry_count %0d, expected %0d",
                                         entry_count, want.count));
            end
            result_count++;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d transactions taken", cycle_count,
                     taken_count);
            $display("FAIL positional_list_store");
            $finish;
        end
    end

endmodule
